[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the tracker RTL. All checks sample on clk.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, masked while rst_n is low
`define PSMT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check that also holds during reset
`define PSMT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/psmt_pkg.sv]
// ----------------------------------------------------------------------------
// psmt_pkg
// Shared types and constants for the PS/2 mouse packet tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package psmt_pkg;

  // Configuration register file
  localparam int CFG_W      = 11;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = 1;

  localparam logic [REG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] SCREEN_WIDTH_RST  = 11'd320;
  localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RST = 11'd200;

  // Pointer position after reset
  localparam int CURSOR_X_RST = 160;
  localparam int CURSOR_Y_RST = 100;

  // Header byte bit positions
  localparam int HDR_BTN_LO = 0;
  localparam int HDR_BTN_HI = 2;
  localparam int HDR_SYNC   = 3;
  localparam int HDR_XSIGN  = 4;
  localparam int HDR_YSIGN  = 5;

  localparam int BTN_W = 3;

  // Packet byte position
  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_XMOVE  = 2'd1,
    PH_YMOVE  = 2'd2
  } phase_t;

  // Per-transaction status flags
  typedef struct packed {
    logic packet_done;
    logic byte_discarded;
  } result_flags_t;

endpackage

`default_nettype wire

[rtl/psmt_cfg_regs.sv]
// ----------------------------------------------------------------------------
// psmt_cfg_regs
// APB-style register file holding the screen width and height.
// ----------------------------------------------------------------------------
`default_nettype none

module psmt_cfg_regs (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [psmt_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [psmt_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic      [psmt_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                                  pready,
  output logic      [psmt_pkg::CFG_W-1:0]       screen_width,
  output logic      [psmt_pkg::CFG_W-1:0]       screen_height
);

  logic [psmt_pkg::CFG_W-1:0]     width_r;
  logic [psmt_pkg::CFG_W-1:0]     height_r;
  logic [psmt_pkg::REG_IDX_W-1:0] reg_idx;
  logic                           wr_en;

  // Word address selects the register
  assign reg_idx = paddr[2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= psmt_pkg::SCREEN_WIDTH_RST;
      height_r <= psmt_pkg::SCREEN_HEIGHT_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        psmt_pkg::REG_SCREEN_WIDTH:  width_r  <= pwdata[psmt_pkg::CFG_W-1:0];
        psmt_pkg::REG_SCREEN_HEIGHT: height_r <= pwdata[psmt_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (reg_idx)
      psmt_pkg::REG_SCREEN_WIDTH:
        prdata = {{(psmt_pkg::CFG_DATA_W-psmt_pkg::CFG_W){1'b0}}, width_r};
      psmt_pkg::REG_SCREEN_HEIGHT:
        prdata = {{(psmt_pkg::CFG_DATA_W-psmt_pkg::CFG_W){1'b0}}, height_r};
      default:
        prdata = '0;
    endcase
  end

  assign screen_width  = width_r;
  assign screen_height = height_r;

endmodule

`default_nettype wire

[rtl/psmt_core.sv]
// ----------------------------------------------------------------------------
// psmt_core
// Packet phase tracking, delta decode and clamped pointer update.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module psmt_core #(
  parameter int COORD_BITS = 10
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         advance,
  input  wire logic [7:0]                   rx_byte,
  input  wire logic [psmt_pkg::CFG_W-1:0]   screen_width,
  input  wire logic [psmt_pkg::CFG_W-1:0]   screen_height,
  output logic      [COORD_BITS-1:0]        pos_x,
  output logic      [COORD_BITS-1:0]        pos_y,
  output logic      [psmt_pkg::BTN_W-1:0]   buttons,
  output psmt_pkg::result_flags_t           flags
);

  // Signed working width: covers cursor +/- 256 and the 11-bit size
  localparam int SUM_W = (COORD_BITS + 2 > psmt_pkg::CFG_W + 2) ?
                         COORD_BITS + 2 : psmt_pkg::CFG_W + 2;
  localparam logic signed [SUM_W-1:0] COORD_LIMIT = SUM_W'(1) << COORD_BITS;

  psmt_pkg::phase_t           phase_r, phase_nxt;
  logic [7:0]                 header_r, header_nxt;
  logic [7:0]                 xmove_r, xmove_nxt;
  logic [COORD_BITS-1:0]      cur_x_r, cur_x_nxt;
  logic [COORD_BITS-1:0]      cur_y_r, cur_y_nxt;
  logic [psmt_pkg::BTN_W-1:0] btn_r, btn_nxt;
  psmt_pkg::result_flags_t    flags_c;

  logic signed [SUM_W-1:0]    dx_w, dy_w;
  logic signed [SUM_W-1:0]    sum_x, sum_y;
  logic signed [SUM_W-1:0]    lim_x, lim_y;
  logic [COORD_BITS-1:0]      clamp_x, clamp_y;

  // Effective axis size: zero acts as one, capped at the coordinate range
  function automatic logic signed [SUM_W-1:0] eff_size(
    input logic [psmt_pkg::CFG_W-1:0] size
  );
    logic signed [SUM_W-1:0] s;
    s = signed'({{(SUM_W-psmt_pkg::CFG_W){1'b0}}, size});
    if (size == '0) s = SUM_W'(1);
    if (s > COORD_LIMIT) s = COORD_LIMIT;
    return s;
  endfunction

  function automatic logic [COORD_BITS-1:0] clamp_axis(
    input logic signed [SUM_W-1:0] v,
    input logic signed [SUM_W-1:0] lim
  );
    logic signed [SUM_W-1:0] top;
    top = lim - SUM_W'(1);
    if (v < 0)
      return '0;
    else if (v >= lim)
      return top[COORD_BITS-1:0];
    else
      return v[COORD_BITS-1:0];
  endfunction

  // Nine-bit two's complement deltas, sign bits from the header
  assign dx_w = {{(SUM_W-8){header_r[psmt_pkg::HDR_XSIGN]}}, xmove_r};
  assign dy_w = {{(SUM_W-8){header_r[psmt_pkg::HDR_YSIGN]}}, rx_byte};

  // X adds, Y subtracts (rows grow downward)
  assign sum_x = signed'({{(SUM_W-COORD_BITS){1'b0}}, cur_x_r}) + dx_w;
  assign sum_y = signed'({{(SUM_W-COORD_BITS){1'b0}}, cur_y_r}) - dy_w;
  assign lim_x = eff_size(screen_width);
  assign lim_y = eff_size(screen_height);
  assign clamp_x = clamp_axis(sum_x, lim_x);
  assign clamp_y = clamp_axis(sum_y, lim_y);

  // Next packet phase
  always_comb begin
    unique case (phase_r)
      psmt_pkg::PH_XMOVE: phase_nxt = psmt_pkg::PH_YMOVE;
      psmt_pkg::PH_YMOVE: phase_nxt = psmt_pkg::PH_HEADER;
      default: begin
        phase_nxt = rx_byte[psmt_pkg::HDR_SYNC] ? psmt_pkg::PH_XMOVE
                                                : psmt_pkg::PH_HEADER;
      end
    endcase
  end

  // Datapath and flags per phase
  always_comb begin
    header_nxt = header_r;
    xmove_nxt  = xmove_r;
    cur_x_nxt  = cur_x_r;
    cur_y_nxt  = cur_y_r;
    btn_nxt    = btn_r;
    flags_c    = '0;
    unique case (phase_r)
      psmt_pkg::PH_XMOVE: begin
        xmove_nxt = rx_byte;
      end
      psmt_pkg::PH_YMOVE: begin
        btn_nxt   = header_r[psmt_pkg::HDR_BTN_HI:psmt_pkg::HDR_BTN_LO];
        cur_x_nxt = clamp_x;
        cur_y_nxt = clamp_y;
        flags_c.packet_done = 1'b1;
      end
      default: begin
        if (rx_byte[psmt_pkg::HDR_SYNC]) begin
          header_nxt = rx_byte;
        end else begin
          flags_c.byte_discarded = 1'b1;
        end
      end
    endcase
  end

  // State registers, updated once per transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= psmt_pkg::PH_HEADER;
      header_r <= '0;
      xmove_r  <= '0;
      cur_x_r  <= COORD_BITS'(psmt_pkg::CURSOR_X_RST);
      cur_y_r  <= COORD_BITS'(psmt_pkg::CURSOR_Y_RST);
      btn_r    <= '0;
    end else if (advance) begin
      phase_r  <= phase_nxt;
      header_r <= header_nxt;
      xmove_r  <= xmove_nxt;
      cur_x_r  <= cur_x_nxt;
      cur_y_r  <= cur_y_nxt;
      btn_r    <= btn_nxt;
    end
  end

  assign pos_x   = cur_x_nxt;
  assign pos_y   = cur_y_nxt;
  assign buttons = btn_nxt;
  assign flags   = flags_c;

  // Checks
  `PSMT_ASSERT(a_flags_excl, !(flags_c.packet_done && flags_c.byte_discarded), "done and discard together")
  `PSMT_ASSERT(a_packet_wraps, (advance && phase_r == psmt_pkg::PH_YMOVE) |=> (phase_r == psmt_pkg::PH_HEADER), "phase did not return to header")
  `PSMT_ASSERT(a_btn_hold, (advance && !flags_c.packet_done) |=> $stable(btn_r), "buttons moved without a packet")
  `PSMT_ASSERT(a_drop_resync, (advance && flags_c.byte_discarded) |=> (phase_r == psmt_pkg::PH_HEADER && $stable(header_r)), "discarded byte left header phase")

endmodule

`default_nettype wire

[rtl/ps2_mouse_packet_tracker_top.sv]
// Flow: a byte accepted into the input register passes through the core into the
// result register, whose contents appear on out_*.
// Throughput: one byte per cycle unless out_stall holds a full result register; the
// phase and cursor update is a single registered pass from input to result register.
// Reset: synchronous active-low rst_n clears both pipeline valids, returns the
// phase to header search, sets the pointer to (160, 100) and the screen to 320x200.
// ----------------------------------------------------------------------------
// ps2_mouse_packet_tracker_top
// Assembles PS/2 mouse bytes into packets and tracks a clamped pointer.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2_mouse_packet_tracker_top #(
  parameter int COORD_BITS = 10
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // byte input channel
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [7:0]                       in_rx_byte,
  // result channel
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic      [COORD_BITS-1:0]            out_pos_x,
  output logic      [COORD_BITS-1:0]            out_pos_y,
  output logic      [psmt_pkg::BTN_W-1:0]       out_buttons,
  output logic                                  out_packet_done,
  output logic                                  out_byte_discarded,
  // configuration port
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [psmt_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [psmt_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic      [psmt_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                                  pready
);

  logic                       s1_valid_r, s1_valid_nxt;
  logic [7:0]                 s1_byte_r;
  logic                       in_fire;
  logic                       advance;
  logic                       out_valid_r, out_valid_nxt;
  logic [COORD_BITS-1:0]      pos_x_r, pos_y_r, pos_x_c, pos_y_c;
  logic [psmt_pkg::BTN_W-1:0] btn_r, btn_c;
  psmt_pkg::result_flags_t    flags_r, flags_c;
  logic [psmt_pkg::CFG_W-1:0] screen_width, screen_height;

  psmt_cfg_regs u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .screen_width  (screen_width),
    .screen_height (screen_height)
  );

  // Stage 1 moves on whenever the result register is free or draining
  assign advance  = s1_valid_r & (~out_valid_r | ~out_stall);
  assign in_stall = s1_valid_r & out_valid_r & out_stall;
  assign in_fire  = in_valid & ~in_stall;

  psmt_core #(
    .COORD_BITS (COORD_BITS)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .advance       (advance),
    .rx_byte       (s1_byte_r),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .pos_x         (pos_x_c),
    .pos_y         (pos_y_c),
    .buttons       (btn_c),
    .flags         (flags_c)
  );

  // Valid bits for both stages
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (~out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Input byte register
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (advance) begin
      pos_x_r <= pos_x_c;
      pos_y_r <= pos_y_c;
      btn_r   <= btn_c;
      flags_r <= flags_c;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_pos_x          = pos_x_r;
  assign out_pos_y          = pos_y_r;
  assign out_buttons        = btn_r;
  assign out_packet_done    = flags_r.packet_done;
  assign out_byte_discarded = flags_r.byte_discarded;

endmodule

`default_nettype wire

[tb/sv/ps2_mouse_packet_tracker_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2_mouse_packet_tracker_checker
// Watches the byte, result and register channels of the packet tracker. It
// keeps its own copy of the packet and pointer state, predicts the report of
// each accepted byte and compares every accepted result against the oldest
// prediction.
// ----------------------------------------------------------------------------

module ps2_mouse_packet_tracker_checker #(
  parameter int COORD_BITS = 10
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // byte channel
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic [7:0]                          in_rx_byte,
  // result channel
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic [COORD_BITS-1:0]               out_pos_x,
  input  logic [COORD_BITS-1:0]               out_pos_y,
  input  logic [psmt_pkg::BTN_W-1:0]          out_buttons,
  input  logic                                out_packet_done,
  input  logic                                out_byte_discarded,
  // register port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic                                pready,
  input  logic [psmt_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [psmt_pkg::CFG_DATA_W-1:0]     pwdata,
  // status for the top
  output int                                  errors,
  output int                                  pending
);

  import psmt_pkg::*;

  localparam int COORD_LIMIT = 1 << COORD_BITS;

  typedef struct {
    logic [COORD_BITS-1:0] pos_x;
    logic [COORD_BITS-1:0] pos_y;
    logic [BTN_W-1:0]      buttons;
    logic                  packet_done;
    logic                  byte_discarded;
  } pointer_report_t;

  pointer_report_t pending_reports[$];

  // Shadow of the block's registers and packet state
  logic [CFG_W-1:0]      scr_width;
  logic [CFG_W-1:0]      scr_height;
  phase_t                phase;
  logic [7:0]            hdr_byte;
  logic [7:0]            xmove_byte;
  logic [COORD_BITS-1:0] cur_x;
  logic [COORD_BITS-1:0] cur_y;
  logic [BTN_W-1:0]      btn_bits;

  initial begin
    errors  = 0;
    pending = 0;
  end

  // Clamp a coordinate to 0 .. size-1; size 0 acts as 1, oversize as the limit
  function automatic logic [COORD_BITS-1:0] clamp_coord(input int v, input logic [CFG_W-1:0] size);
    int lim;
    lim = int'(size);
    if (lim == 0) lim = 1;
    if (lim > COORD_LIMIT) lim = COORD_LIMIT;
    if (v < 0) return '0;
    if (v >= lim) return COORD_BITS'(lim - 1);
    return COORD_BITS'(v);
  endfunction

  // Advance the shadow state by one byte and return the report it causes
  function automatic pointer_report_t track_byte(input logic [7:0] b);
    pointer_report_t r;
    int dx;
    int dy;
    r.packet_done    = 1'b0;
    r.byte_discarded = 1'b0;
    case (phase)
      PH_XMOVE: begin
        xmove_byte = b;
        phase      = PH_YMOVE;
      end
      PH_YMOVE: begin
        dx = int'(xmove_byte) - (hdr_byte[HDR_XSIGN] ? 256 : 0);
        dy = int'(b) - (hdr_byte[HDR_YSIGN] ? 256 : 0);
        btn_bits = hdr_byte[HDR_BTN_HI:HDR_BTN_LO];
        cur_x    = clamp_coord(int'(cur_x) + dx, scr_width);
        cur_y    = clamp_coord(int'(cur_y) - dy, scr_height);
        phase    = PH_HEADER;
        r.packet_done = 1'b1;
      end
      default: begin
        // header search; the unused phase value lands here too
        if (!b[HDR_SYNC]) begin
          r.byte_discarded = 1'b1;
          phase = PH_HEADER;
        end else begin
          hdr_byte = b;
          phase    = PH_XMOVE;
        end
      end
    endcase
    r.pos_x   = cur_x;
    r.pos_y   = cur_y;
    r.buttons = btn_bits;
    return r;
  endfunction

  // Sample all channels at the rising edge
  always @(posedge clk) begin
    pointer_report_t exp_r;
    if (!rst_n) begin
      scr_width  = SCREEN_WIDTH_RST;
      scr_height = SCREEN_HEIGHT_RST;
      phase      = PH_HEADER;
      hdr_byte   = '0;
      xmove_byte = '0;
      cur_x      = COORD_BITS'(CURSOR_X_RST);
      cur_y      = COORD_BITS'(CURSOR_Y_RST);
      btn_bits   = '0;
      pending_reports.delete();
    end else begin
      // result transaction against the oldest prediction
      if (out_valid && !out_stall) begin
        if (pending_reports.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected result x=%0d y=%0d btn=%0d done=%0b drop=%0b",
                     $realtime, out_pos_x, out_pos_y, out_buttons, out_packet_done,
                     out_byte_discarded);
        end else begin
          exp_r = pending_reports.pop_front();
          if (out_pos_x !== exp_r.pos_x || out_pos_y !== exp_r.pos_y ||
              out_buttons !== exp_r.buttons || out_packet_done !== exp_r.packet_done ||
              out_byte_discarded !== exp_r.byte_discarded) begin
            errors++;
            if (errors <= 10)
              $display("%0t: mismatch exp x=%0d y=%0d btn=%0d done=%0b drop=%0b, got x=%0d y=%0d btn=%0d done=%0b drop=%0b",
                       $realtime, exp_r.pos_x, exp_r.pos_y, exp_r.buttons, exp_r.packet_done,
                       exp_r.byte_discarded, out_pos_x, out_pos_y, out_buttons,
                       out_packet_done, out_byte_discarded);
          end
        end
      end
      // register write
      if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
        if (paddr[CFG_ADDR_W-1:2] == REG_SCREEN_WIDTH)
          scr_width = pwdata[CFG_W-1:0];
        else if (paddr[CFG_ADDR_W-1:2] == REG_SCREEN_HEIGHT)
          scr_height = pwdata[CFG_W-1:0];
      end
      // byte transaction
      if (in_valid && !in_stall)
        pending_reports.push_back(track_byte(in_rx_byte));
    end
    pending = pending_reports.size();
  end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the PS/2 mouse packet tracker: directed header, sign and clamp
// cases, then random packets and noise under several screen sizes, with
// random gaps on the byte side and random stalls on the result side.
// ----------------------------------------------------------------------------

module tb;

  import psmt_pkg::*;

  localparam int COORD_BITS = 10;
  localparam int IDLE_LIMIT = 500;
  localparam int BYTES_PER_SETTING = 250;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [7:0]            in_rx_byte;
  logic                  out_valid;
  logic                  out_stall;
  logic [COORD_BITS-1:0] out_pos_x;
  logic [COORD_BITS-1:0] out_pos_y;
  logic [BTN_W-1:0]      out_buttons;
  logic                  out_packet_done;
  logic                  out_byte_discarded;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  int  errors;
  int  pending;
  int  idle_cycles;
  int  sent_bytes;
  bit  no_idle;

  ps2_mouse_packet_tracker_top #(.COORD_BITS(COORD_BITS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_rx_byte(in_rx_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_buttons(out_buttons),
    .out_packet_done(out_packet_done), .out_byte_discarded(out_byte_discarded),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  ps2_mouse_packet_tracker_checker #(.COORD_BITS(COORD_BITS)) u_track_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_rx_byte(in_rx_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_buttons(out_buttons),
    .out_packet_done(out_packet_done), .out_byte_discarded(out_byte_discarded),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .errors(errors), .pending(pending)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: cycles in a row with no transaction of any kind
  initial idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
        (psel && penable && pwrite && pready) || !rst_n)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Result side: after each result transaction, stall for a random count
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        n = no_idle ? 0 : $urandom_range(0, 5);
        if (n > 0) begin
          @(negedge clk);
          out_stall = 1'b1;
          repeat (n) @(posedge clk);
          @(negedge clk);
          out_stall = 1'b0;
        end
      end
    end
  end

  // One byte transaction, preceded by a random gap
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (sent_bytes % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
    gap = no_idle ? 0 : $urandom_range(0, 5);
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    in_valid   = 1'b1;
    in_rx_byte = b;
    do @(posedge clk); while (in_stall);
    sent_bytes++;
  endtask

  task automatic send_packet(input logic [7:0] hdr, input logic [7:0] xb, input logic [7:0] yb);
    send_byte(hdr);
    send_byte(xb);
    send_byte(yb);
  endtask

  // Let every outstanding result arrive
  task automatic drain;
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Register write: setup cycle then access cycle; upper data bits are junk
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = ($urandom() & ~32'h7FF) | CFG_DATA_W'(val);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Mostly well-formed packets with random content, some stray bytes
  task automatic random_traffic(input int count);
    int n;
    logic [7:0] hdr;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 99) < 85) begin
        hdr = 8'($urandom());
        hdr[HDR_SYNC] = 1'b1;
        send_packet(hdr, 8'($urandom()), 8'($urandom()));
        n += 3;
      end else begin
        send_byte(8'($urandom()));
        n += 1;
      end
    end
  endtask

  initial begin
    logic [CFG_W-1:0] w_list[7];
    logic [CFG_W-1:0] h_list[7];
    in_valid   = 1'b0;
    in_rx_byte = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    no_idle    = 1'b0;
    sent_bytes = 0;
    rst_n      = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: discards, full-scale deltas both ways, clamps, overflow bits
    send_byte(8'h00);
    send_byte(8'hF7);
    send_packet(8'h08, 8'hFF, 8'h00);   // +255 in x, right edge
    send_packet(8'h38, 8'h00, 8'h00);   // -256 both, bottom edge
    send_packet(8'h1F, 8'h00, 8'h00);   // left edge, all buttons
    send_packet(8'h08, 8'h00, 8'hFF);   // +255 in y, top edge
    send_packet(8'hCF, 8'h01, 8'h01);   // overflow bits ignored
    send_packet(8'hFF, 8'hFF, 8'hFF);   // -1 both
    send_packet(8'h0A, 8'h00, 8'h07);   // data bytes lacking bit 3
    drain();

    // Screen settings: minimal, zero, full, oversized, mixed, random, reset
    w_list = '{11'd1, 11'd0, 11'd1024, 11'd2047, 11'd1025, 11'd1, 11'd320};
    h_list = '{11'd1, 11'd0, 11'd1024, 11'd2047, 11'd3,    11'd1, 11'd200};
    w_list[5] = CFG_W'($urandom_range(1, 1024));
    h_list[5] = CFG_W'($urandom_range(1, 1024));
    for (int s = 0; s < 7; s++) begin
      write_reg(REG_SCREEN_WIDTH, w_list[s]);
      write_reg(REG_SCREEN_HEIGHT, h_list[s]);
      random_traffic(BYTES_PER_SETTING);
      drain();
    end

    repeat (10) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/psmt_pkg.sv
rtl/psmt_cfg_regs.sv
rtl/psmt_core.sv
rtl/ps2_mouse_packet_tracker_top.sv
tb/sv/ps2_mouse_packet_tracker_checker.sv
tb/sv/tb.sv
